// ===== sv/wrs_pkg.sv =====
// Shared types, constants and helpers for the weighted reservoir sampler.
package wrs_pkg;

  localparam int MaxEntries = 16;
  localparam int IdxW = $clog2(MaxEntries);
  localparam int CntW = $clog2(MaxEntries + 1);

  localparam logic [31:0] Ln2Q32 = 32'd2977044472;
  localparam logic signed [31:0] KeyMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] KeyMin = 32'sh8000_0000;

  localparam logic OpInsert = 1'b0;
  localparam logic OpRead = 1'b1;

  localparam logic CfgWeightMode = 1'b0;
  localparam logic CfgCapacity = 1'b1;

  typedef struct packed {
    logic operation;
    logic [31:0] item_id;
    logic signed [31:0] weight;
    logic [31:0] uniform;
    logic [3:0] read_index;
  } wrs_in_t;

  typedef struct packed {
    logic accepted;
    logic [4:0] entry_count;
    logic read_valid;
    logic [31:0] read_item;
    logic signed [31:0] read_key;
  } wrs_out_t;

  function automatic logic [CntW-1:0] eff_cap(input logic [4:0] c);
    logic [CntW-1:0] r;
    if (c == 5'd0) begin
      r = CntW'(1);
    end else if (32'(c) > MaxEntries) begin
      r = CntW'(MaxEntries);
    end else begin
      r = CntW'(c);
    end
    return r;
  endfunction

endpackage

// ===== sv/wrs_key.sv =====
// Key generator: sequencer around one shared multiplier and a shift-subtract divider.
module wrs_key import wrs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               mode_i,
  input  logic signed [31:0] weight_i,
  input  logic [31:0]        uniform_i,
  output logic               done_o,
  output logic signed [31:0] key_o
);

  typedef enum logic [3:0] {
    KIdle, KNorm, KSquare, KMulE, KCalcE, KDiv, KDivEnd, KMulL, KFinL
  } kstate_e;

  kstate_e st_q;
  logic [31:0] x_q;
  logic [4:0] p_q;
  logic [15:0] frac_q;
  logic [5:0] it_q;
  logic second_q;
  logic mode_q;
  logic signed [31:0] w_q;
  logic [63:0] prod_q;
  logic [37:0] n_q;
  logic [31:0] rem_q;
  logic [37:0] quo_q;
  logic signed [31:0] key_q;
  logic done_q;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [20:0] lg;
  logic [21:0] t_val;
  logic signed [21:0] d_val;
  logic [21:0] mag;
  logic [63:0] rsum;
  logic [21:0] rnd;
  logic [21:0] e_val;
  logic [31:0] trial;
  logic ge;
  logic signed [33:0] sr;
  logic signed [33:0] k34;

  assign lg = {p_q, frac_q};
  assign t_val = 22'h20_0000 - {1'b0, lg};
  assign d_val = $signed({1'b0, lg}) - 22'sh10_0000;
  assign mag = d_val[21] ? 22'(-d_val) : 22'(d_val);
  assign rsum = prod_q + 64'h8000_0000;
  assign rnd = rsum[53:32];
  assign e_val = (rnd == 22'd0) ? 22'd1 : rnd;
  assign trial = {rem_q[30:0], n_q[37]};
  assign ge = trial >= {1'b0, w_q[30:0]};
  assign sr = d_val[21] ? -$signed({12'd0, rnd}) : $signed({12'd0, rnd});
  assign k34 = sr - 34'(w_q);

  always_comb begin
    unique case (st_q)
      KMulE:   mul_a = {10'd0, t_val};
      KMulL:   mul_a = {10'd0, mag};
      default: mul_a = x_q;
    endcase
    mul_b = (st_q == KSquare) ? x_q : Ln2Q32;
    mul_p = 64'(mul_a) * 64'(mul_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= KIdle;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (st_q)
        KIdle: begin
          if (start_i) begin
            x_q <= (uniform_i == 32'd0) ? 32'd1 : uniform_i;
            p_q <= 5'd31;
            frac_q <= '0;
            second_q <= 1'b0;
            mode_q <= mode_i;
            w_q <= weight_i;
            st_q <= KNorm;
          end
        end
        KNorm: begin
          if (x_q[31]) begin
            it_q <= '0;
            st_q <= KSquare;
          end else begin
            x_q <= x_q << 1;
            p_q <= p_q - 5'd1;
          end
        end
        KSquare: begin
          x_q <= mul_p[63] ? mul_p[63:32] : mul_p[62:31];
          frac_q <= {frac_q[14:0], mul_p[63]};
          it_q <= it_q + 6'd1;
          if (it_q == 6'd15) begin
            st_q <= second_q ? KMulL : KMulE;
          end
        end
        KMulE: begin
          prod_q <= mul_p;
          st_q <= KCalcE;
        end
        KCalcE: begin
          if (mode_q) begin
            x_q <= {10'd0, e_val};
            p_q <= 5'd31;
            frac_q <= '0;
            second_q <= 1'b1;
            st_q <= KNorm;
          end else if (w_q[31] || w_q == 32'sd0) begin
            key_q <= KeyMax;
            done_q <= 1'b1;
            st_q <= KIdle;
          end else begin
            n_q <= {e_val, 16'd0};
            rem_q <= '0;
            quo_q <= '0;
            it_q <= '0;
            st_q <= KDiv;
          end
        end
        KDiv: begin
          rem_q <= ge ? trial - {1'b0, w_q[30:0]} : trial;
          quo_q <= {quo_q[36:0], ge};
          n_q <= n_q << 1;
          it_q <= it_q + 6'd1;
          if (it_q == 6'd37) begin
            st_q <= KDivEnd;
          end
        end
        KDivEnd: begin
          key_q <= (|quo_q[37:31]) ? KeyMax : $signed({1'b0, quo_q[30:0]});
          done_q <= 1'b1;
          st_q <= KIdle;
        end
        KMulL: begin
          prod_q <= mul_p;
          st_q <= KFinL;
        end
        KFinL: begin
          if (k34 > 34'(KeyMax)) begin
            key_q <= KeyMax;
          end else if (k34 < 34'(KeyMin)) begin
            key_q <= KeyMin;
          end else begin
            key_q <= k34[31:0];
          end
          done_q <= 1'b1;
          st_q <= KIdle;
        end
        default: st_q <= KIdle;
      endcase
    end
  end

  assign done_o = done_q;
  assign key_o = key_q;

endmodule

// ===== sv/wrs_store.sv =====
// Entry store with one write port, one read port and odd-even transposition sort cells.
module wrs_store import wrs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [CntW-1:0]    cap_i,
  input  logic               wr_en_i,
  input  logic [IdxW-1:0]    wr_idx_i,
  input  logic signed [31:0] wr_key_i,
  input  logic [31:0]        wr_id_i,
  input  logic               sort_start_i,
  output logic               sort_busy_o,
  input  logic [IdxW-1:0]    rd_idx_i,
  output logic signed [31:0] rd_key_o,
  output logic [31:0]        rd_id_o
);

  logic signed [31:0] key_q [MaxEntries];
  logic [31:0] id_q [MaxEntries];
  logic signed [31:0] key_d [MaxEntries];
  logic [31:0] id_d [MaxEntries];
  logic busy_q;
  logic [CntW-1:0] pass_q;

  always_comb begin
    for (int i = 0; i < MaxEntries; i++) begin
      key_d[i] = key_q[i];
      id_d[i] = id_q[i];
    end
    if (busy_q) begin
      for (int j = 0; j < MaxEntries - 1; j++) begin
        if ((j % 2) == 32'(pass_q[0]) && CntW'(j + 1) < cap_i && key_q[j] > key_q[j+1]) begin
          key_d[j] = key_q[j+1];
          key_d[j+1] = key_q[j];
          id_d[j] = id_q[j+1];
          id_d[j+1] = id_q[j];
        end
      end
    end else if (wr_en_i) begin
      key_d[wr_idx_i] = wr_key_i;
      id_d[wr_idx_i] = wr_id_i;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxEntries; i++) begin
      key_q[i] <= key_d[i];
      id_q[i] <= id_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pass_q <= '0;
    end else if (sort_start_i) begin
      busy_q <= 1'b1;
      pass_q <= '0;
    end else if (busy_q) begin
      pass_q <= pass_q + CntW'(1);
      if (pass_q == cap_i - CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign sort_busy_o = busy_q;
  assign rd_key_o = key_q[rd_idx_i];
  assign rd_id_o = id_q[rd_idx_i];

endmodule

// ===== sv/weighted_reservoir_sampler.sv =====
// Weighted reservoir sampler top level: control sequencer, registers and output slot.
// Each transaction is handled alone. A read skips the key unit. An insert runs the key
// unit: a leading-one search and repeated squaring for the log, then either a divide
// (linear mode) or a second log (log mode); a linear weight that is not positive skips
// the divide. Sorting follows once the store is full. The key unit shares one 32x32
// multiplier and uses a one-bit-per-cycle divider.
module weighted_reservoir_sampler import wrs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  wrs_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output wrs_out_t out_data_o,
  input  logic     cfg_valid_i,
  output logic     cfg_ready_o,
  input  logic     cfg_index_i,
  input  logic [4:0] cfg_data_i
);

  typedef enum logic [2:0] {SIdle, SKey, SChk, SSort, SDone} state_e;

  state_e st_q;
  logic mode_q;
  logic [4:0] cap_q;
  logic [CntW-1:0] cnt_q;
  logic cfg_sort_q;
  logic acc_q;
  wrs_in_t in_q;
  wrs_out_t out_q;
  logic out_valid_q;

  logic [CntW-1:0] eff;
  logic [CntW-1:0] new_eff;
  logic in_acc;
  logic cfg_acc;
  logic key_start;
  logic key_done;
  logic signed [31:0] key_val;
  logic wr_en;
  logic [IdxW-1:0] wr_idx;
  logic sort_start;
  logic sort_busy;
  logic [IdxW-1:0] rd_idx;
  logic signed [31:0] rd_key;
  logic [31:0] rd_id;
  logic out_free;
  logic rvalid;

  assign eff = eff_cap(cap_q);
  assign new_eff = eff_cap(cfg_data_i);
  assign cfg_ready_o = st_q == SIdle;
  assign cfg_acc = cfg_valid_i && cfg_ready_o;
  assign in_stall_o = st_q != SIdle || cfg_valid_i;
  assign in_acc = in_valid_i && !in_stall_o;
  assign key_start = in_acc && in_data_i.operation == OpInsert;
  assign out_free = !out_valid_q || !out_stall_i;
  assign rd_idx = (st_q == SChk) ? IdxW'(eff - CntW'(1)) : in_q.read_index;
  assign rvalid = in_q.operation == OpRead && CntW'(in_q.read_index) < cnt_q;

  always_comb begin
    wr_en = 1'b0;
    wr_idx = IdxW'(eff - CntW'(1));
    sort_start = 1'b0;
    if (st_q == SChk) begin
      if (cnt_q < eff) begin
        wr_en = 1'b1;
        wr_idx = cnt_q[IdxW-1:0];
        sort_start = cnt_q + CntW'(1) == eff;
      end else if (key_val < rd_key) begin
        wr_en = 1'b1;
        sort_start = 1'b1;
      end
    end else if (cfg_acc && cfg_index_i == CfgCapacity && cnt_q >= new_eff) begin
      sort_start = 1'b1;
    end
  end

  wrs_key u_key (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (key_start),
    .mode_i   (mode_q),
    .weight_i (in_data_i.weight),
    .uniform_i(in_data_i.uniform),
    .done_o   (key_done),
    .key_o    (key_val)
  );

  wrs_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cap_i       ((cfg_acc && cfg_index_i == CfgCapacity) ? new_eff : eff),
    .wr_en_i     (wr_en),
    .wr_idx_i    (wr_idx),
    .wr_key_i    (key_val),
    .wr_id_i     (in_q.item_id),
    .sort_start_i(sort_start),
    .sort_busy_o (sort_busy),
    .rd_idx_i    (rd_idx),
    .rd_key_o    (rd_key),
    .rd_id_o     (rd_id)
  );

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      mode_q <= 1'b0;
      cap_q <= 5'd16;
      cnt_q <= '0;
      cfg_sort_q <= 1'b0;
      acc_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (st_q == SDone && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (st_q)
        SIdle: begin
          acc_q <= 1'b0;
          if (cfg_acc) begin
            if (cfg_index_i == CfgWeightMode) begin
              mode_q <= cfg_data_i[0];
            end else begin
              cap_q <= cfg_data_i;
              if (cnt_q >= new_eff) begin
                cnt_q <= new_eff;
                cfg_sort_q <= 1'b1;
                st_q <= SSort;
              end
            end
          end else if (in_acc) begin
            st_q <= (in_data_i.operation == OpInsert) ? SKey : SDone;
          end
        end
        SKey: begin
          if (key_done) begin
            st_q <= SChk;
          end
        end
        SChk: begin
          acc_q <= wr_en;
          if (cnt_q < eff) begin
            cnt_q <= cnt_q + CntW'(1);
          end
          cfg_sort_q <= 1'b0;
          st_q <= sort_start ? SSort : SDone;
        end
        SSort: begin
          if (!sort_busy) begin
            cfg_sort_q <= 1'b0;
            st_q <= cfg_sort_q ? SIdle : SDone;
          end
        end
        SDone: begin
          if (out_free) begin
            out_q.accepted <= acc_q;
            out_q.entry_count <= 5'(cnt_q);
            out_q.read_valid <= rvalid;
            out_q.read_item <= rvalid ? rd_id : 32'd0;
            out_q.read_key <= rvalid ? rd_key : 32'sd0;
            st_q <= SIdle;
          end
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for weighted_reservoir_sampler: scoreboard model plus random stimulus.
`timescale 1ns / 1ps

module tb;
  import wrs_pkg::*;

  class sample_scoreboard;
    bit                 weight_mode;
    logic [4:0]         capacity;
    logic signed [31:0] keys [MaxEntries];
    logic [31:0]        ids [MaxEntries];
    int                 held;
    wrs_out_t           expected_q [$];
    int                 errors;
    int                 n_insert;
    int                 n_read;
    int                 n_taken;

    function new();
      weight_mode = 1'b0;
      capacity = 5'd16;
      held = 0;
      errors = 0;
      n_insert = 0;
      n_read = 0;
      n_taken = 0;
    endfunction

    function int limit();
      int c;
      c = capacity;
      if (c < 1) c = 1;
      if (c > MaxEntries) c = MaxEntries;
      return c;
    endfunction

    function logic [31:0] log2_q16(logic [31:0] x);
      int p;
      logic [63:0] m;
      logic [15:0] frac;
      if (x == 0) x = 1;
      p = 31;
      while (!x[p]) p--;
      m = 64'(x) << (31 - p);
      frac = '0;
      for (int i = 0; i < 16; i++) begin
        m = (m * m) >> 31;
        frac = frac << 1;
        if (m >= 64'h1_0000_0000) begin
          frac[0] = 1'b1;
          m = m >> 1;
        end
      end
      return (32'(p) << 16) | 32'(frac);
    endfunction

    function logic signed [31:0] sample_key(logic signed [31:0] w, logic [31:0] u);
      logic [63:0] t;
      logic [63:0] e;
      logic [63:0] q;
      longint d;
      longint r;
      longint k;
      logic [63:0] mag;
      if (u == 0) u = 1;
      t = 64'(32'd32 << 16) - 64'(log2_q16(u));
      e = (t * 64'(Ln2Q32) + 64'h8000_0000) >> 32;
      if (e == 0) e = 1;
      if (!weight_mode) begin
        if (w <= 0) return KeyMax;
        q = (e << 16) / 64'(w);
        if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
        return 32'(q);
      end
      d = longint'(log2_q16(32'(e))) - longint'(32'd16 << 16);
      mag = (d < 0) ? 64'(-d) : 64'(d);
      r = longint'((mag * 64'(Ln2Q32) + 64'h8000_0000) >> 32);
      if (d < 0) r = -r;
      k = r - longint'(w);
      if (k > 64'sh7FFF_FFFF) k = 64'sh7FFF_FFFF;
      if (k < -64'sh8000_0000) k = -64'sh8000_0000;
      return 32'(k);
    endfunction

    function void sort_entries(int n);
      logic signed [31:0] k;
      logic [31:0] id;
      int j;
      for (int i = 1; i < n; i++) begin
        k = keys[i];
        id = ids[i];
        j = i;
        while (j > 0 && keys[j-1] > k) begin
          keys[j] = keys[j-1];
          ids[j] = ids[j-1];
          j--;
        end
        keys[j] = k;
        ids[j] = id;
      end
    endfunction

    function void write_reg(logic idx, logic [4:0] val);
      if (idx == CfgWeightMode) begin
        weight_mode = val[0];
      end else begin
        capacity = val;
        if (held >= limit()) begin
          held = limit();
          sort_entries(held);
        end
      end
    endfunction

    function void note_input(wrs_in_t x);
      wrs_out_t r;
      logic signed [31:0] k;
      int c;
      r = '0;
      if (x.operation == OpInsert) begin
        n_insert++;
        c = limit();
        k = sample_key(x.weight, x.uniform);
        if (held < c) begin
          keys[held] = k;
          ids[held] = x.item_id;
          held++;
          r.accepted = 1'b1;
          if (held == c) sort_entries(c);
        end else if (k < keys[c-1]) begin
          keys[c-1] = k;
          ids[c-1] = x.item_id;
          r.accepted = 1'b1;
          sort_entries(c);
        end
        if (r.accepted) n_taken++;
      end else begin
        n_read++;
        if (x.read_index < held) begin
          r.read_valid = 1'b1;
          r.read_item = ids[x.read_index];
          r.read_key = keys[x.read_index];
        end
      end
      r.entry_count = 5'(held);
      expected_q.push_back(r);
    endfunction

    function void compare(string name, logic [31:0] e, logic [31:0] g);
      if (e !== g) begin
        errors++;
        $display("%0t mismatch %s: expected %h actual %h", $time, name, e, g);
      end
    endfunction

    function void check_result(wrs_out_t got);
      wrs_out_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual %h", $time, got);
        return;
      end
      e = expected_q.pop_front();
      compare("accepted", 32'(e.accepted), 32'(got.accepted));
      compare("entry_count", 32'(e.entry_count), 32'(got.entry_count));
      compare("read_valid", 32'(e.read_valid), 32'(got.read_valid));
      compare("read_item", e.read_item, got.read_item);
      compare("read_key", e.read_key, got.read_key);
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  wrs_in_t    in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  wrs_out_t   out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_index_i = 1'b0;
  logic [4:0] cfg_data_i = '0;

  sample_scoreboard sb = new();
  int idle_mode = 0;
  int quiet_cycles = 0;
  int cfg_writes = 0;
  logic [4:0] caps [12] = '{5'd1, 5'd4, 5'd0, 5'd31, 5'd9, 5'd16, 5'd5,
                            5'd5, 5'd12, 5'd2, 5'd16, 5'd7};

  weighted_reservoir_sampler u_dut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function bit sender_gap();
    return (idle_mode == 1 && $urandom_range(99) < 66) ||
           (idle_mode == 3 && $urandom_range(99) < 15);
  endfunction

  always @(posedge clk_i) begin
    out_stall_i <= (idle_mode == 2 && $urandom_range(99) < 66) ||
                   (idle_mode == 3 && $urandom_range(99) < 15);
  end

  always @(negedge clk_i) begin
    if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else if (rst_ni) begin
      quiet_cycles++;
      if (quiet_cycles >= 20000) begin
        $display("%0t watchdog: no transaction for %0d cycles", $time, quiet_cycles);
        $display("tb: errors");
        $finish;
      end
    end
  end

  task automatic send_item(wrs_in_t x);
    while (sender_gap()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= x;
    do @(negedge clk_i); while (in_stall_o);
    sb.note_input(x);
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [4:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(negedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    cfg_writes++;
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic insert(logic [31:0] id, logic [31:0] w, logic [31:0] u);
    wrs_in_t x;
    x = '0;
    x.operation = OpInsert;
    x.item_id = id;
    x.weight = w;
    x.uniform = u;
    x.read_index = 4'($urandom);
    send_item(x);
  endtask

  task automatic read_at(logic [3:0] idx);
    wrs_in_t x;
    x.operation = OpRead;
    x.item_id = $urandom;
    x.weight = $urandom;
    x.uniform = $urandom;
    x.read_index = idx;
    send_item(x);
  endtask

  task automatic random_items(int n);
    logic [31:0] w;
    logic [31:0] u;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 25) begin
        read_at(4'($urandom));
      end else begin
        case ($urandom_range(5))
          0: w = $urandom;
          1: w = -$urandom_range(65536);
          2: w = 32'($urandom_range(200000, 1));
          3: w = {$urandom_range(1) ? 16'hFFFF : 16'h0, 16'($urandom)};
          default: w = 32'($urandom_range(4096, 16)) << 8;
        endcase
        case ($urandom_range(9))
          0: u = 32'($urandom_range(2));
          1: u = 32'hFFFF_FFFF - $urandom_range(3);
          default: u = $urandom;
        endcase
        insert($urandom, w, u);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: linear weights, full capacity
    insert(32'h0, 32'h0, 32'h1234_5678);
    insert(32'hFFFF_FFFF, 32'h8000_0000, 32'h0);
    insert(32'h1, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    insert(32'h2, 32'h1, 32'h0);
    insert(32'h3, 32'h0001_0000, 32'h8000_0000);
    insert(32'h4, 32'h0001_0000, 32'h8000_0000);
    insert(32'h5, 32'h0001_0000, 32'h0000_0001);
    read_at(4'd0);
    read_at(4'd6);
    read_at(4'd7);
    read_at(4'd15);
    for (int i = 0; i < 10; i++) insert(32'h100 + i, 32'h0002_0000, $urandom);
    read_at(4'd15);
    read_at(4'd0);
    drain();
    write_cfg(CfgWeightMode, 5'd1);
    insert(32'hA, 32'h8000_0000, 32'h0);
    insert(32'hB, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    insert(32'hC, 32'h0, 32'h0000_0001);
    read_at(4'd0);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      idle_mode = ph % 4;
      write_cfg(CfgWeightMode, 5'(ph % 2));
      write_cfg(CfgCapacity, caps[ph]);
      random_items(90);
      drain();
    end

    $display("tb: %0d inserts (%0d kept), %0d reads, %0d register writes, 4 idle patterns",
             sb.n_insert, sb.n_taken, sb.n_read, cfg_writes);
    if (sb.expected_q.size() != 0) begin
      sb.errors++;
      $display("%0t %0d results never arrived", $time, sb.expected_q.size());
    end
    if (sb.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/wrs_pkg.sv
sv/wrs_key.sv
sv/wrs_store.sv
sv/weighted_reservoir_sampler.sv
tb/tb.sv
